// File: design/two_voice_note_sequencer_top_assert.svh
// assertion macros for the two-voice note sequencer checker
// expects a clock i_clk and an active-low reset i_rst_n in scope
`ifndef TWO_VOICE_NOTE_SEQUENCER_TOP_ASSERT_SVH
`define TWO_VOICE_NOTE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define TVNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TVNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tvns_pkg.sv
// shared types, codes and helpers of the two-voice note sequencer
// no dependencies
`default_nettype none
package tvns_pkg;

    localparam int NOTE_DEPTH = 256;
    localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
    localparam int NOTE_W     = 32;

    localparam logic [2:0] KIND_LOAD   = 3'd0;
    localparam logic [2:0] KIND_THEME  = 3'd1;
    localparam logic [2:0] KIND_EFFECT = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SILENCE = 2'd1;
    localparam logic [1:0] ACT_PLAY    = 2'd2;

    localparam logic [8:0] MAX_RUN = 9'd256;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now;
        logic [7:0]  address;
        logic [15:0] frequency;
        logic [15:0] duration;
        logic [7:0]  start_req;
        logic [8:0]  length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] tone_frequency;
        logic        effect_active;
        logic        theme_active;
    } t_out_item;

    typedef struct packed {
        logic               we;
        logic [NOTE_AW-1:0] waddr;
        logic [NOTE_W-1:0]  wdata;
        logic [NOTE_AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic        done;
        logic [1:0]  action;
        logic [15:0] tone_frequency;
        logic        effect_on;
        logic        theme_on;
    } t_ctrl_res;

    function automatic logic [NOTE_AW-1:0] note_addr(input logic [7:0] base,
                                                      input logic [7:0] pos);
        logic [8:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        return NOTE_AW'(sum);
    endfunction

    function automatic logic expired(input logic [31:0] now,
                                     input logic [31:0] end_tick);
        logic [31:0] diff;
        diff = now - end_tick;
        return ~diff[31];
    endfunction

endpackage
`default_nettype wire

// File: design/tvns_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module tvns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: design/tvns_ctrl.sv
// sequencer control: command decode, voice registers, catch-up walk over note memory
// depends on tvns_pkg
`default_nettype none
module tvns_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire tvns_pkg::t_in_item  i_item,
    input  wire logic [31:0]         i_rdata,
    output logic                     o_busy,
    output tvns_pkg::t_ram_req       o_ram,
    output tvns_pkg::t_ctrl_res      o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NOTE = 3'd1;
    localparam logic [2:0] S_TCHK = 3'd2;
    localparam logic [2:0] S_TACC = 3'd3;
    localparam logic [2:0] S_ECHK = 3'd4;
    localparam logic [2:0] S_EACC = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_kind, n_kind;
    logic [31:0] r_now, n_now;
    logic [7:0]  r_t_base, n_t_base;
    logic [8:0]  r_t_count, n_t_count;
    logic [7:0]  r_t_pos, n_t_pos;
    logic [31:0] r_t_end, n_t_end;
    logic        r_t_on, n_t_on;
    logic [7:0]  r_e_base, n_e_base;
    logic [8:0]  r_e_count, n_e_count;
    logic [7:0]  r_e_pos, n_e_pos;
    logic [31:0] r_e_end, n_e_end;
    logic        r_e_on, n_e_on;
    logic [8:0]  r_steps, n_steps;
    logic        r_t_chg, n_t_chg;
    logic        r_e_chg, n_e_chg;
    logic        r_e_done, n_e_done;

    logic [8:0]  len_sat;
    logic [8:0]  t_p1;
    logic [8:0]  e_p1;
    logic [15:0] rd_freq;
    logic [15:0] rd_dur;

    assign len_sat = (i_item.length > tvns_pkg::MAX_RUN) ? tvns_pkg::MAX_RUN : i_item.length;
    assign t_p1    = {1'b0, r_t_pos} + 9'd1;
    assign e_p1    = {1'b0, r_e_pos} + 9'd1;
    assign rd_freq = i_rdata[31:16];
    assign rd_dur  = i_rdata[15:0];

    assign o_busy         = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_now     = r_now;
        n_t_base  = r_t_base;
        n_t_count = r_t_count;
        n_t_pos   = r_t_pos;
        n_t_end   = r_t_end;
        n_t_on    = r_t_on;
        n_e_base  = r_e_base;
        n_e_count = r_e_count;
        n_e_pos   = r_e_pos;
        n_e_end   = r_e_end;
        n_e_on    = r_e_on;
        n_steps   = r_steps;
        n_t_chg   = r_t_chg;
        n_e_chg   = r_e_chg;
        n_e_done  = r_e_done;

        o_ram.we    = 1'b0;
        o_ram.waddr = tvns_pkg::NOTE_AW'(i_item.address);
        o_ram.wdata = {i_item.frequency, i_item.duration};
        o_ram.raddr = '0;

        o_res.done           = 1'b0;
        o_res.action         = tvns_pkg::ACT_NONE;
        o_res.tone_frequency = '0;
        o_res.effect_on      = r_e_on;
        o_res.theme_on       = r_t_on;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind = i_item.kind;
                    n_now  = i_item.now;
                    unique case (i_item.kind)
                        tvns_pkg::KIND_LOAD: begin
                            o_ram.we   = (32'(i_item.address) < tvns_pkg::NOTE_DEPTH);
                            o_res.done = 1'b1;
                        end
                        tvns_pkg::KIND_THEME: begin
                            n_e_base  = '0;
                            n_e_count = '0;
                            n_e_pos   = '0;
                            n_e_end   = '0;
                            n_e_on    = 1'b0;
                            if (len_sat == 9'd0) begin
                                n_t_base     = '0;
                                n_t_count    = '0;
                                n_t_pos      = '0;
                                n_t_end      = '0;
                                n_t_on       = 1'b0;
                                o_res.done   = 1'b1;
                                o_res.action = tvns_pkg::ACT_SILENCE;
                            end else begin
                                n_t_base    = i_item.start_req;
                                n_t_count   = len_sat;
                                n_t_pos     = '0;
                                n_t_on      = 1'b1;
                                o_ram.raddr = tvns_pkg::note_addr(i_item.start_req, 8'd0);
                                n_state     = S_NOTE;
                            end
                        end
                        tvns_pkg::KIND_EFFECT: begin
                            if (len_sat == 9'd0) begin
                                o_res.done = 1'b1;
                            end else begin
                                n_e_base    = i_item.start_req;
                                n_e_count   = len_sat;
                                n_e_pos     = '0;
                                n_e_on      = 1'b1;
                                o_ram.raddr = tvns_pkg::note_addr(i_item.start_req, 8'd0);
                                n_state     = S_NOTE;
                            end
                        end
                        tvns_pkg::KIND_STOP: begin
                            n_t_base     = '0;
                            n_t_count    = '0;
                            n_t_pos      = '0;
                            n_t_end      = '0;
                            n_t_on       = 1'b0;
                            n_e_base     = '0;
                            n_e_count    = '0;
                            n_e_pos      = '0;
                            n_e_end      = '0;
                            n_e_on       = 1'b0;
                            o_res.done   = 1'b1;
                            o_res.action = tvns_pkg::ACT_SILENCE;
                        end
                        tvns_pkg::KIND_TICK: begin
                            n_steps  = '0;
                            n_t_chg  = 1'b0;
                            n_e_chg  = 1'b0;
                            n_e_done = 1'b0;
                            n_state  = S_TCHK;
                        end
                        default: begin
                            o_res.done = 1'b1;
                        end
                    endcase
                end
            end
            S_NOTE: begin
                if (rd_freq == 16'd0) begin
                    o_res.action = tvns_pkg::ACT_SILENCE;
                end else begin
                    o_res.action         = tvns_pkg::ACT_PLAY;
                    o_res.tone_frequency = rd_freq;
                end
                if (r_kind == tvns_pkg::KIND_THEME) begin
                    n_t_end = r_now + 32'(rd_dur);
                end else if (r_kind == tvns_pkg::KIND_EFFECT) begin
                    n_e_end = r_now + 32'(rd_dur);
                end
                o_res.done = 1'b1;
                n_state    = S_IDLE;
            end
            S_TCHK: begin
                if (r_t_on && (r_t_count != 9'd0) && (r_steps < r_t_count)
                        && tvns_pkg::expired(r_now, r_t_end)) begin
                    n_t_pos     = (t_p1 >= r_t_count) ? 8'd0 : t_p1[7:0];
                    o_ram.raddr = tvns_pkg::note_addr(r_t_base, n_t_pos);
                    n_steps     = r_steps + 9'd1;
                    n_t_chg     = 1'b1;
                    n_state     = S_TACC;
                end else begin
                    n_state = S_ECHK;
                end
            end
            S_TACC: begin
                n_t_end = r_t_end + 32'(rd_dur);
                n_state = S_TCHK;
            end
            S_ECHK: begin
                if (r_e_on && (r_e_count != 9'd0) && tvns_pkg::expired(r_now, r_e_end)) begin
                    if (e_p1 >= r_e_count) begin
                        n_e_base  = '0;
                        n_e_count = '0;
                        n_e_pos   = '0;
                        n_e_end   = '0;
                        n_e_on    = 1'b0;
                        n_e_done  = 1'b1;
                        n_state   = S_EMIT;
                    end else begin
                        n_e_pos     = e_p1[7:0];
                        o_ram.raddr = tvns_pkg::note_addr(r_e_base, e_p1[7:0]);
                        n_e_chg     = 1'b1;
                        n_state     = S_EACC;
                    end
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EACC: begin
                n_e_end = r_e_end + 32'(rd_dur);
                n_state = S_ECHK;
            end
            S_EMIT: begin
                priority if (r_e_on) begin
                    if (r_e_chg) begin
                        o_ram.raddr = tvns_pkg::note_addr(r_e_base, r_e_pos);
                        n_state     = S_NOTE;
                    end else begin
                        o_res.done = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_e_done || r_t_chg) begin
                    if (r_t_on && (r_t_count != 9'd0)) begin
                        o_ram.raddr = tvns_pkg::note_addr(r_t_base, r_t_pos);
                        n_state     = S_NOTE;
                    end else begin
                        o_res.done   = 1'b1;
                        o_res.action = tvns_pkg::ACT_SILENCE;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_res.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_t_base  <= '0;
            r_t_count <= '0;
            r_t_pos   <= '0;
            r_t_end   <= '0;
            r_t_on    <= 1'b0;
            r_e_base  <= '0;
            r_e_count <= '0;
            r_e_pos   <= '0;
            r_e_end   <= '0;
            r_e_on    <= 1'b0;
            r_steps   <= '0;
            r_t_chg   <= 1'b0;
            r_e_chg   <= 1'b0;
            r_e_done  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_t_base  <= n_t_base;
            r_t_count <= n_t_count;
            r_t_pos   <= n_t_pos;
            r_t_end   <= n_t_end;
            r_t_on    <= n_t_on;
            r_e_base  <= n_e_base;
            r_e_count <= n_e_count;
            r_e_pos   <= n_e_pos;
            r_e_end   <= n_e_end;
            r_e_on    <= n_e_on;
            r_steps   <= n_steps;
            r_t_chg   <= n_t_chg;
            r_e_chg   <= n_e_chg;
            r_e_done  <= n_e_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_now  <= n_now;
    end

endmodule
`default_nettype wire

// File: design/two_voice_note_sequencer_top.sv
// channel   direction  ports                       handshake
// command   in         start, busy, i_item         start & !busy
// result    out        o_strobe, o_result          o_strobe, one cycle, no stall
//
// load, stop, undefined kinds and empty runs: result in the cycle after the item
// start theme/effect: one note memory read, result through the note state and the result register
// tick: theme check/accumulate walk, effect check/accumulate walk, emit state, then the note
//   state when a note is read for the command; theme walk bounded by one pass of its run
// reset clears voice state, control state and the strobe; note memory is undefined until loaded
// top level: note memory ram, sequencer control and result register
`default_nettype none
module two_voice_note_sequencer_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire tvns_pkg::t_in_item  i_item,
    output logic                     o_strobe,
    output tvns_pkg::t_out_item      o_result
);

    tvns_pkg::t_ram_req  ram_req;
    tvns_pkg::t_ctrl_res ctrl_res;
    logic [31:0]         ram_rdata;

    logic        r_strobe;
    logic [1:0]  r_action;
    logic [15:0] r_freq;

    tvns_ram #(
        .WIDTH (tvns_pkg::NOTE_W),
        .DEPTH (tvns_pkg::NOTE_DEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    tvns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_rdata (ram_rdata),
        .o_busy  (busy),
        .o_ram   (ram_req),
        .o_res   (ctrl_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ctrl_res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_res.done) begin
            r_action <= ctrl_res.action;
            r_freq   <= ctrl_res.tone_frequency;
        end
    end

    assign o_strobe                = r_strobe;
    assign o_result.action         = r_action;
    assign o_result.tone_frequency = r_freq;
    assign o_result.effect_active  = ctrl_res.effect_on;
    assign o_result.theme_active   = ctrl_res.theme_on;

endmodule
`default_nettype wire

// File: design/tvns_checker.sv
// port-level checker for the two-voice note sequencer, bound to the top level
// depends on tvns_pkg and two_voice_note_sequencer_top_assert.svh
`default_nettype none
`include "two_voice_note_sequencer_top_assert.svh"
module tvns_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire tvns_pkg::t_in_item  i_item,
    input wire logic                o_strobe,
    input wire tvns_pkg::t_out_item o_result
);

    `TVNS_ASSERT_NEXT(a_item_progress, start && !busy, o_strobe || busy, "item neither answered nor in work")
    `TVNS_ASSERT_NEXT(a_no_spurious, !start && !busy, !o_strobe, "result without an item")
    `TVNS_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result shown while still busy")
    `TVNS_ASSERT_NOW(a_freq_match, o_strobe, (o_result.action == tvns_pkg::ACT_PLAY) == (o_result.tone_frequency != 16'd0), "tone frequency does not match action")
    `TVNS_ASSERT_NEXT(a_stop_silence, start && !busy && (i_item.kind == tvns_pkg::KIND_STOP), o_strobe && (o_result.action == tvns_pkg::ACT_SILENCE) && !o_result.theme_active && !o_result.effect_active, "stop item not silenced")

endmodule

bind two_voice_note_sequencer_top tvns_checker u_tvns_checker (.*);
`default_nettype wire
